// ----- sv/gbtc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package gbtc_pkg;

  // Field widths
  localparam int CMD_W  = 2;
  localparam int PIX_W  = 12;
  localparam int FRM_W  = 13;
  localparam int SPAN_W = 8;
  localparam int GAIN_W = 17;
  localparam int PER_W  = 10;
  localparam int ANG_W  = 18;
  localparam int TS_W   = 32;

  // Stream word widths (fields packed from bit 0, padded to whole bytes)
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_FIELD_W = 2 * ANG_W + TS_W + 1;
  localparam int OUT_TDATA_W = 72;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

  // Configuration port
  localparam int CFG_AW    = 5;
  localparam int CFG_DW    = 32;
  localparam int REG_IDX_W = 3;

  localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_YAW_SPAN     = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_PITCH_SPAN   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_GAIN         = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_TICK_PERIOD  = 3'd5;

  localparam logic [FRM_W-1:0]  RST_FRAME_WIDTH  = 13'd1920;
  localparam logic [FRM_W-1:0]  RST_FRAME_HEIGHT = 13'd1080;
  localparam logic [SPAN_W-1:0] RST_YAW_SPAN     = 8'd30;
  localparam logic [SPAN_W-1:0] RST_PITCH_SPAN   = 8'd20;
  localparam logic [GAIN_W-1:0] RST_GAIN         = 17'd3277;
  localparam logic [PER_W-1:0]  RST_TICK_PERIOD  = 10'd33;

  // Angle limits in 1/256 degree
  localparam int ANGLE_MAX    = 131071;
  localparam int ANGLE_MIN    = -131072;
  localparam int HALF_TURN    = 46080;
  localparam int FULL_TURN    = 92160;
  localparam int QUARTER_TURN = 23040;
  localparam int ANG_FRAC     = 8;

  // Shared multiplier: signed A times zero-extended B
  localparam int MA_W = TS_W + 1;
  localparam int MB_W = GAIN_W + 1;
  localparam int MP_W = MA_W + MB_W;

  // Box offset divider: 30-bit magnitude over 2*size, two quotient bits per cycle
  localparam int DIV_W     = 30;
  localparam int DIVR_W    = FRM_W + 2;
  localparam int DIV_RADIX = 2;
  localparam int DIV_STEPS = DIV_W / DIV_RADIX;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  typedef enum logic [CMD_W-1:0] {
    CMD_BOX   = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_TRACK = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [CMD_W-1:0] {
    KIND_TARGET  = 2'd0,
    KIND_CURRENT = 2'd1,
    KIND_MOTION  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    MUL_BOX_Y = 3'd0,
    MUL_BOX_P = 3'd1,
    MUL_YAW   = 3'd2,
    MUL_PITCH = 3'd3,
    MUL_TS    = 3'd4
  } mul_sel_t;

  typedef struct packed {
    logic [FRM_W-1:0]  frame_width;
    logic [FRM_W-1:0]  frame_height;
    logic [SPAN_W-1:0] yaw_span_deg;
    logic [SPAN_W-1:0] pitch_span_deg;
    logic [GAIN_W-1:0] gain_q16;
    logic [PER_W-1:0]  tick_period_ms;
  } cfg_t;

  typedef struct packed {
    logic [PIX_W-1:0] box_x;
    logic [PIX_W-1:0] box_y;
    logic [PIX_W-1:0] box_w;
    logic [PIX_W-1:0] box_h;
    logic             track_locked;
  } item_t;

  typedef struct packed {
    kind_t                   kind;
    logic signed [ANG_W-1:0] yaw;
    logic signed [ANG_W-1:0] pitch;
    logic [TS_W-1:0]         timestamp_ms;
    logic                    moving;
  } res_t;

  typedef struct packed {
    logic     latch;
    logic     tick_inc;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     div_load;
    logic     div_pitch;
    logic     div_step;
    logic     set_tgt_yaw;
    logic     set_tgt_pitch;
    logic     set_cur_yaw;
    logic     set_cur_pitch;
    logic     set_ts;
    logic     emit;
  } dp_cmd_t;

  typedef struct packed {
    logic in_valid;
    cmd_t in_cmd;
    logic out_free;
  } ctrl_stat_t;

endpackage

`default_nettype wire

// ----- sv/gbtc_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module gbtc_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  gbtc_pkg::ctrl_stat_t  stat,
  output logic                  in_ready,
  output gbtc_pkg::dp_cmd_t     dcmd
);

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_BOX_MUL  = 8'b0000_0010,
    S_DIV_LOAD = 8'b0000_0100,
    S_DIV_RUN  = 8'b0000_1000,
    S_BOX_SET  = 8'b0001_0000,
    S_TICK_MUL = 8'b0010_0000,
    S_TICK_SET = 8'b0100_0000,
    S_EMIT     = 8'b1000_0000
  } state_t;

  // Phase: which angle (or the timestamp) the shared units are working on.
  localparam logic [1:0] PH_YAW   = 2'd0;
  localparam logic [1:0] PH_PITCH = 2'd1;
  localparam logic [1:0] PH_TS    = 2'd2;

  localparam logic [gbtc_pkg::STEP_W-1:0] STEP_LAST =
    gbtc_pkg::STEP_W'(gbtc_pkg::DIV_STEPS - 1);

  state_t                        state_r, state_nxt;
  logic [1:0]                    phase_r, phase_nxt;
  logic [gbtc_pkg::STEP_W-1:0]   step_r, step_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      phase_r <= PH_YAW;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      step_r  <= step_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    step_nxt  = step_r;
    in_ready  = 1'b0;
    dcmd      = '0;
    dcmd.mul_sel = gbtc_pkg::MUL_BOX_Y;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (stat.in_valid) begin
          dcmd.latch = 1'b1;
          phase_nxt  = PH_YAW;
          case (stat.in_cmd)
            gbtc_pkg::CMD_BOX: begin
              state_nxt = S_BOX_MUL;
            end
            gbtc_pkg::CMD_TICK: begin
              dcmd.tick_inc = 1'b1;
              state_nxt     = S_TICK_MUL;
            end
            gbtc_pkg::CMD_TRACK: begin
              state_nxt = S_EMIT;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_BOX_MUL: begin
        dcmd.mul_en  = 1'b1;
        dcmd.mul_sel = (phase_r == PH_PITCH) ? gbtc_pkg::MUL_BOX_P : gbtc_pkg::MUL_BOX_Y;
        state_nxt    = S_DIV_LOAD;
      end
      S_DIV_LOAD: begin
        dcmd.div_load  = 1'b1;
        dcmd.div_pitch = (phase_r == PH_PITCH);
        step_nxt       = '0;
        state_nxt      = S_DIV_RUN;
      end
      S_DIV_RUN: begin
        dcmd.div_step = 1'b1;
        if (step_r == STEP_LAST) begin
          state_nxt = S_BOX_SET;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      S_BOX_SET: begin
        if (phase_r == PH_PITCH) begin
          dcmd.set_tgt_pitch = 1'b1;
          state_nxt          = S_EMIT;
        end else begin
          dcmd.set_tgt_yaw = 1'b1;
          phase_nxt        = PH_PITCH;
          state_nxt        = S_BOX_MUL;
        end
      end
      S_TICK_MUL: begin
        dcmd.mul_en = 1'b1;
        case (phase_r)
          PH_YAW:   dcmd.mul_sel = gbtc_pkg::MUL_YAW;
          PH_PITCH: dcmd.mul_sel = gbtc_pkg::MUL_PITCH;
          default:  dcmd.mul_sel = gbtc_pkg::MUL_TS;
        endcase
        state_nxt = S_TICK_SET;
      end
      S_TICK_SET: begin
        case (phase_r)
          PH_YAW:   dcmd.set_cur_yaw   = 1'b1;
          PH_PITCH: dcmd.set_cur_pitch = 1'b1;
          default:  dcmd.set_ts        = 1'b1;
        endcase
        if (phase_r == PH_TS) begin
          state_nxt = S_EMIT;
        end else begin
          phase_nxt = phase_r + 1'b1;
          state_nxt = S_TICK_MUL;
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          dcmd.emit = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- sv/gbtc_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none

module gbtc_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  gbtc_pkg::cfg_t     cfg,
  input  gbtc_pkg::dp_cmd_t  dcmd,
  input  gbtc_pkg::cmd_t     in_cmd,
  input  gbtc_pkg::item_t    in_item,
  output gbtc_pkg::res_t     res
);

  localparam int ANG_W  = gbtc_pkg::ANG_W;
  localparam int CTR_W  = gbtc_pkg::PIX_W + 2;
  localparam int OFF_W  = CTR_W + 2;
  localparam int MA_W   = gbtc_pkg::MA_W;
  localparam int MB_W   = gbtc_pkg::MB_W;
  localparam int MP_W   = gbtc_pkg::MP_W;
  localparam int DIV_W  = gbtc_pkg::DIV_W;
  localparam int DIVR_W = gbtc_pkg::DIVR_W;
  localparam int SUM_W  = DIV_W + 2;
  localparam int Q16    = 16;
  localparam int MOVE_W = ANG_W + 2;
  localparam int NY_W   = MOVE_W + 2;
  localparam int FRM_W  = gbtc_pkg::FRM_W;
  localparam int FR     = gbtc_pkg::ANG_FRAC;

  // Architectural state
  logic signed [ANG_W-1:0]        cur_yaw_r, cur_pitch_r, tgt_yaw_r, tgt_pitch_r;
  logic [gbtc_pkg::TS_W-1:0]      tick_cnt_r;

  // Working registers
  gbtc_pkg::cmd_t                 item_cmd_r;
  gbtc_pkg::item_t                item_r;
  logic signed [MP_W-1:0]         prod_r;
  logic [DIV_W-1:0]               dvd_r;
  logic [DIVR_W-1:0]              rem_r, dvs_r;
  logic                           neg_r;
  logic [gbtc_pkg::TS_W-1:0]      ts_r;

  logic [FRM_W-1:0]               size_x, size_y;
  logic [CTR_W-1:0]               ctr_x, ctr_y;
  logic signed [OFF_W-1:0]        off_x, off_y;
  logic signed [ANG_W:0]          diff_yaw, diff_pitch;
  logic signed [MA_W-1:0]         mul_a;
  logic signed [MB_W-1:0]         mul_b;
  logic [MP_W-1:0]                prod_mag;
  logic [DIVR_W-1:0]              trial, rem_t, rem_step;
  logic [DIV_W-1:0]               dvd_t, dvd_step;
  logic                           qbit;
  logic signed [DIV_W:0]          quo_s;
  logic signed [SUM_W-1:0]        box_yaw_sum, box_pitch_sum;
  logic signed [MOVE_W-1:0]       move;
  logic signed [NY_W-1:0]         ny, ny_wrap, np;
  logic signed [ANG_W-1:0]        new_yaw, new_pitch;

  function automatic logic signed [ANG_W-1:0] sat_angle(input logic signed [SUM_W-1:0] v);
    if (v > SUM_W'(gbtc_pkg::ANGLE_MAX)) begin
      return ANG_W'(gbtc_pkg::ANGLE_MAX);
    end else if (v < SUM_W'(gbtc_pkg::ANGLE_MIN)) begin
      return ANG_W'(gbtc_pkg::ANGLE_MIN);
    end
    return v[ANG_W-1:0];
  endfunction

  // Box centre offsets: 2*pos + len - size, with sizes below two taken as two.
  assign size_x = (cfg.frame_width < FRM_W'(2)) ? FRM_W'(2) : cfg.frame_width;
  assign size_y = (cfg.frame_height < FRM_W'(2)) ? FRM_W'(2) : cfg.frame_height;
  assign ctr_x  = {1'b0, item_r.box_x, 1'b0} + {2'b00, item_r.box_w};
  assign ctr_y  = {1'b0, item_r.box_y, 1'b0} + {2'b00, item_r.box_h};
  assign off_x  = $signed({{(OFF_W-CTR_W){1'b0}}, ctr_x})
                - $signed({{(OFF_W-FRM_W){1'b0}}, size_x});
  assign off_y  = $signed({{(OFF_W-CTR_W){1'b0}}, ctr_y})
                - $signed({{(OFF_W-FRM_W){1'b0}}, size_y});

  assign diff_yaw   = $signed({tgt_yaw_r[ANG_W-1], tgt_yaw_r})
                    - $signed({cur_yaw_r[ANG_W-1], cur_yaw_r});
  assign diff_pitch = $signed({tgt_pitch_r[ANG_W-1], tgt_pitch_r})
                    - $signed({cur_pitch_r[ANG_W-1], cur_pitch_r});

  always_comb begin
    case (dcmd.mul_sel)
      gbtc_pkg::MUL_BOX_Y: begin
        mul_a = {{(MA_W-OFF_W){off_x[OFF_W-1]}}, off_x};
        mul_b = {{(MB_W-gbtc_pkg::SPAN_W){1'b0}}, cfg.yaw_span_deg};
      end
      gbtc_pkg::MUL_BOX_P: begin
        mul_a = {{(MA_W-OFF_W){off_y[OFF_W-1]}}, off_y};
        mul_b = {{(MB_W-gbtc_pkg::SPAN_W){1'b0}}, cfg.pitch_span_deg};
      end
      gbtc_pkg::MUL_YAW: begin
        mul_a = {{(MA_W-ANG_W-1){diff_yaw[ANG_W]}}, diff_yaw};
        mul_b = {{(MB_W-gbtc_pkg::GAIN_W){1'b0}}, cfg.gain_q16};
      end
      gbtc_pkg::MUL_PITCH: begin
        mul_a = {{(MA_W-ANG_W-1){diff_pitch[ANG_W]}}, diff_pitch};
        mul_b = {{(MB_W-gbtc_pkg::GAIN_W){1'b0}}, cfg.gain_q16};
      end
      gbtc_pkg::MUL_TS: begin
        mul_a = {{(MA_W-gbtc_pkg::TS_W){1'b0}}, tick_cnt_r};
        mul_b = {{(MB_W-gbtc_pkg::PER_W){1'b0}}, cfg.tick_period_ms};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_mag = prod_r[MP_W-1] ? MP_W'(-prod_r) : MP_W'(prod_r);

  // Restoring division, two quotient bits per cycle. The dividend shifts
  // out of the top of dvd_r while quotient bits shift in at the bottom.
  always_comb begin
    rem_t = rem_r;
    dvd_t = dvd_r;
    trial = '0;
    qbit  = 1'b0;
    for (int i = 0; i < gbtc_pkg::DIV_RADIX; i++) begin
      trial = {rem_t[DIVR_W-2:0], dvd_t[DIV_W-1]};
      if (trial >= dvs_r) begin
        rem_t = trial - dvs_r;
        qbit  = 1'b1;
      end else begin
        rem_t = trial;
        qbit  = 1'b0;
      end
      dvd_t = {dvd_t[DIV_W-2:0], qbit};
    end
    rem_step = rem_t;
    dvd_step = dvd_t;
  end

  // Truncating division: the quotient takes the sign of the numerator.
  assign quo_s = neg_r ? -$signed({1'b0, dvd_r}) : $signed({1'b0, dvd_r});

  assign box_yaw_sum   = $signed({{(SUM_W-ANG_W){cur_yaw_r[ANG_W-1]}}, cur_yaw_r})
                       - $signed({quo_s[DIV_W], quo_s});
  assign box_pitch_sum = $signed({{(SUM_W-ANG_W){cur_pitch_r[ANG_W-1]}}, cur_pitch_r})
                       + $signed({quo_s[DIV_W], quo_s});

  // Arithmetic shift by 16 rounds toward minus infinity.
  assign move = prod_r[Q16+MOVE_W-1:Q16];
  assign ny   = $signed({{(NY_W-ANG_W){cur_yaw_r[ANG_W-1]}}, cur_yaw_r})
              + $signed({{(NY_W-MOVE_W){move[MOVE_W-1]}}, move});
  assign np   = $signed({{(NY_W-ANG_W){cur_pitch_r[ANG_W-1]}}, cur_pitch_r})
              + $signed({{(NY_W-MOVE_W){move[MOVE_W-1]}}, move});

  always_comb begin
    if (ny > NY_W'(gbtc_pkg::HALF_TURN)) begin
      ny_wrap = ny - NY_W'(gbtc_pkg::FULL_TURN);
    end else if (ny < NY_W'(-gbtc_pkg::HALF_TURN)) begin
      ny_wrap = ny + NY_W'(gbtc_pkg::FULL_TURN);
    end else begin
      ny_wrap = ny;
    end
    new_yaw = sat_angle({{(SUM_W-NY_W){ny_wrap[NY_W-1]}}, ny_wrap});
    if (np > NY_W'(gbtc_pkg::QUARTER_TURN)) begin
      new_pitch = ANG_W'(gbtc_pkg::QUARTER_TURN);
    end else if (np < NY_W'(-gbtc_pkg::QUARTER_TURN)) begin
      new_pitch = ANG_W'(-gbtc_pkg::QUARTER_TURN);
    end else begin
      new_pitch = np[ANG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_yaw_r   <= '0;
      cur_pitch_r <= '0;
      tgt_yaw_r   <= '0;
      tgt_pitch_r <= '0;
      tick_cnt_r  <= '0;
    end else begin
      if (dcmd.tick_inc) begin
        tick_cnt_r <= tick_cnt_r + 1'b1;
      end
      if (dcmd.set_tgt_yaw) begin
        tgt_yaw_r <= sat_angle(box_yaw_sum);
      end
      if (dcmd.set_tgt_pitch) begin
        tgt_pitch_r <= sat_angle(box_pitch_sum);
      end
      if (dcmd.set_cur_yaw) begin
        cur_yaw_r <= new_yaw;
      end
      if (dcmd.set_cur_pitch) begin
        cur_pitch_r <= new_pitch;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dcmd.latch) begin
      item_cmd_r <= in_cmd;
      item_r     <= in_item;
    end
    if (dcmd.mul_en) begin
      prod_r <= mul_a * mul_b;
    end
    if (dcmd.div_load) begin
      dvd_r <= {prod_mag[DIV_W-FR-1:0], {FR{1'b0}}};
      neg_r <= prod_r[MP_W-1];
      rem_r <= '0;
      dvs_r <= {1'b0, (dcmd.div_pitch ? size_y : size_x), 1'b0};
    end else if (dcmd.div_step) begin
      dvd_r <= dvd_step;
      rem_r <= rem_step;
    end
    if (dcmd.set_ts) begin
      ts_r <= prod_r[gbtc_pkg::TS_W-1:0];
    end
  end

  always_comb begin
    res = '0;
    case (item_cmd_r)
      gbtc_pkg::CMD_BOX: begin
        res.kind  = gbtc_pkg::KIND_TARGET;
        res.yaw   = tgt_yaw_r;
        res.pitch = tgt_pitch_r;
      end
      gbtc_pkg::CMD_TICK: begin
        res.kind         = gbtc_pkg::KIND_CURRENT;
        res.yaw          = cur_yaw_r;
        res.pitch        = cur_pitch_r;
        res.timestamp_ms = ts_r;
      end
      gbtc_pkg::CMD_TRACK: begin
        res.kind   = gbtc_pkg::KIND_MOTION;
        res.moving = item_r.track_locked;
      end
      default: begin
        res = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- sv/gimbal_box_tracking_controller.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Width  Contents
// in_*      in   56+2   word: box edges and size, lock flag; tuser carries the command
// out_*     out  72+2   word: yaw, pitch, timestamp, moving; tuser carries the result kind
// cfg_*     in   32     register writes and reads, six registers at byte addresses 0..20
//
// A detection word runs the shared box divider, which retires two quotient bits a
// cycle over 30 bits, once for yaw and once for pitch. A tick makes three passes
// through the shared multiplier; a tracking word goes straight to the output, and
// an unknown command is dropped without a result.
// Reset (rst_n low at a clock edge) zeroes the pose, targets and tick count and
// restores the register defaults. The input stays ready while the output register
// still holds a result; a finished word waits only if the output is still full.

module gimbal_box_tracking_controller (
  input  logic                               clk,
  input  logic                               rst_n,

  input  logic                               in_tvalid,
  output logic                               in_tready,
  // box_x [11:0], box_y [23:12], box_w [35:24], box_h [47:36], track_locked [48]
  input  logic [gbtc_pkg::IN_TDATA_W-1:0]    in_tdata,
  // command [1:0]
  input  logic [gbtc_pkg::CMD_W-1:0]         in_tuser,

  output logic                               out_tvalid,
  input  logic                               out_tready,
  // yaw [17:0], pitch [35:18], timestamp_ms [67:36], moving [68]
  output logic [gbtc_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // kind [1:0]
  output logic [gbtc_pkg::CMD_W-1:0]         out_tuser,

  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [gbtc_pkg::CFG_AW-1:0]        cfg_paddr,
  input  logic [gbtc_pkg::CFG_DW-1:0]        cfg_pwdata,
  output logic [gbtc_pkg::CFG_DW-1:0]        cfg_prdata,
  output logic                               cfg_pready
);

  gbtc_pkg::cfg_t                   cfg_r;
  gbtc_pkg::item_t                  in_item;
  gbtc_pkg::ctrl_stat_t             stat;
  gbtc_pkg::dp_cmd_t                dcmd;
  gbtc_pkg::res_t                   res;
  gbtc_pkg::res_t                   out_data_r;
  logic                             out_valid_r;
  logic                             cfg_wr;
  logic [gbtc_pkg::REG_IDX_W-1:0]   cfg_idx;

  // Configuration registers. Writes land on the access phase; reads are
  // served combinationally, so the port never inserts wait states.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = cfg_paddr[gbtc_pkg::CFG_AW-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_width    <= gbtc_pkg::RST_FRAME_WIDTH;
      cfg_r.frame_height   <= gbtc_pkg::RST_FRAME_HEIGHT;
      cfg_r.yaw_span_deg   <= gbtc_pkg::RST_YAW_SPAN;
      cfg_r.pitch_span_deg <= gbtc_pkg::RST_PITCH_SPAN;
      cfg_r.gain_q16       <= gbtc_pkg::RST_GAIN;
      cfg_r.tick_period_ms <= gbtc_pkg::RST_TICK_PERIOD;
    end else if (cfg_wr) begin
      case (cfg_idx)
        gbtc_pkg::REG_FRAME_WIDTH:  cfg_r.frame_width    <= cfg_pwdata[gbtc_pkg::FRM_W-1:0];
        gbtc_pkg::REG_FRAME_HEIGHT: cfg_r.frame_height   <= cfg_pwdata[gbtc_pkg::FRM_W-1:0];
        gbtc_pkg::REG_YAW_SPAN:     cfg_r.yaw_span_deg   <= cfg_pwdata[gbtc_pkg::SPAN_W-1:0];
        gbtc_pkg::REG_PITCH_SPAN:   cfg_r.pitch_span_deg <= cfg_pwdata[gbtc_pkg::SPAN_W-1:0];
        gbtc_pkg::REG_GAIN:         cfg_r.gain_q16       <= cfg_pwdata[gbtc_pkg::GAIN_W-1:0];
        gbtc_pkg::REG_TICK_PERIOD:  cfg_r.tick_period_ms <= cfg_pwdata[gbtc_pkg::PER_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      gbtc_pkg::REG_FRAME_WIDTH:  cfg_prdata = gbtc_pkg::CFG_DW'(cfg_r.frame_width);
      gbtc_pkg::REG_FRAME_HEIGHT: cfg_prdata = gbtc_pkg::CFG_DW'(cfg_r.frame_height);
      gbtc_pkg::REG_YAW_SPAN:     cfg_prdata = gbtc_pkg::CFG_DW'(cfg_r.yaw_span_deg);
      gbtc_pkg::REG_PITCH_SPAN:   cfg_prdata = gbtc_pkg::CFG_DW'(cfg_r.pitch_span_deg);
      gbtc_pkg::REG_GAIN:         cfg_prdata = gbtc_pkg::CFG_DW'(cfg_r.gain_q16);
      gbtc_pkg::REG_TICK_PERIOD:  cfg_prdata = gbtc_pkg::CFG_DW'(cfg_r.tick_period_ms);
      default:                    cfg_prdata = '0;
    endcase
  end

  // Unpack the input word.
  assign in_item.box_x        = in_tdata[11:0];
  assign in_item.box_y        = in_tdata[23:12];
  assign in_item.box_w        = in_tdata[35:24];
  assign in_item.box_h        = in_tdata[47:36];
  assign in_item.track_locked = in_tdata[48];

  // The controller sees the handshake and whether the output register can
  // take a new result in this cycle.
  assign stat.in_valid = in_tvalid;
  assign stat.in_cmd   = gbtc_pkg::cmd_t'(in_tuser);
  assign stat.out_free = !out_valid_r || out_tready;

  gbtc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .stat     (stat),
    .in_ready (in_tready),
    .dcmd     (dcmd)
  );

  gbtc_dp u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .dcmd    (dcmd),
    .in_cmd  (stat.in_cmd),
    .in_item (in_item),
    .res     (res)
  );

  // Output register: decouples the result from the datapath so the next
  // word can be accepted while this one waits for the sink.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (dcmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (dcmd.emit) begin
      out_data_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_data_r.kind;
  assign out_tdata  = {{gbtc_pkg::OUT_PAD_W{1'b0}}, out_data_r.moving,
                       out_data_r.timestamp_ms, out_data_r.pitch, out_data_r.yaw};

`ifndef SYNTH
  // An unknown command is dropped at once and leaves the input ready.
  a_none_stays_ready: assert property (@(posedge clk) disable iff (!rst_n)
      (in_tvalid && in_tready && in_tuser == gbtc_pkg::CMD_NONE) |=> in_tready)
    else $error("input not ready after an unknown command");

  // Any real command moves the sequencer out of idle, which drops the input ready.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
      (in_tvalid && in_tready && in_tuser != gbtc_pkg::CMD_NONE) |=> !in_tready)
    else $error("input ready right after accepting a command");

  // A current pose always carries a pitch inside the quarter-turn clamp.
  a_pitch_clamped: assert property (@(posedge clk) disable iff (!rst_n)
      (out_tvalid && out_tuser == gbtc_pkg::KIND_CURRENT) |->
      ($signed(out_data_r.pitch) <= gbtc_pkg::QUARTER_TURN &&
       $signed(out_data_r.pitch) >= -gbtc_pkg::QUARTER_TURN))
    else $error("current pitch outside the clamp");

  // A motion result carries no pose and no timestamp.
  a_motion_clean: assert property (@(posedge clk) disable iff (!rst_n)
      (out_tvalid && out_tuser == gbtc_pkg::KIND_MOTION) |->
      (out_data_r.yaw == '0 && out_data_r.pitch == '0 && out_data_r.timestamp_ms == '0))
    else $error("motion result with pose or timestamp bits set");
`endif

endmodule

`default_nettype wire

// ----- tb/gimbal_box_tracking_controller_test.sv -----
`timescale 1ns / 1ps

module gimbal_box_tracking_controller_test;
  import gbtc_pkg::*;

  // One word offered to the input stream: the command and the fields that ride with it.
  typedef struct {
    cmd_t             cmd;
    logic [PIX_W-1:0] x;
    logic [PIX_W-1:0] y;
    logic [PIX_W-1:0] w;
    logic [PIX_W-1:0] h;
    logic             locked;
  } gimbal_word_t;

  // One result word as it is expected to leave the block.
  typedef struct {
    kind_t                   kind;
    logic signed [ANG_W-1:0] yaw;
    logic signed [ANG_W-1:0] pitch;
    logic [TS_W-1:0]         stamp;
    logic                    moving;
  } pose_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [CMD_W-1:0]       in_tuser = '0;

  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [CMD_W-1:0]       out_tuser;

  logic                   cfg_psel = 1'b0;
  logic                   cfg_penable = 1'b0;
  logic                   cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0]      cfg_paddr = '0;
  logic [CFG_DW-1:0]      cfg_pwdata = '0;
  logic [CFG_DW-1:0]      cfg_prdata;
  logic                   cfg_pready;

  gimbal_box_tracking_controller u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Words waiting to be offered, and the poses the block still owes us.
  gimbal_word_t cmd_backlog[$];
  pose_word_t   expected_poses[$];
  gimbal_word_t word_on_bus;

  // Shadow of the configuration registers, as last written.
  logic [FRM_W-1:0]  frame_w    = RST_FRAME_WIDTH;
  logic [FRM_W-1:0]  frame_h    = RST_FRAME_HEIGHT;
  logic [SPAN_W-1:0] yaw_span   = RST_YAW_SPAN;
  logic [SPAN_W-1:0] pitch_span = RST_PITCH_SPAN;
  logic [GAIN_W-1:0] gain       = RST_GAIN;
  logic [PER_W-1:0]  tick_ms    = RST_TICK_PERIOD;

  // Shadow of the gimbal state: pose, aim point and tick counter.
  logic signed [ANG_W-1:0] cur_yaw    = '0;
  logic signed [ANG_W-1:0] cur_pitch  = '0;
  logic signed [ANG_W-1:0] tgt_yaw    = '0;
  logic signed [ANG_W-1:0] tgt_pitch  = '0;
  logic [TS_W-1:0]         tick_total = '0;

  // Flow control knobs set by the stimulus sequence.
  logic no_idle   = 1'b0;
  logic hold_req  = 1'b0;
  logic hold_done = 1'b0;
  int   hold_left = 0;
  int   mismatches = 0;

  // Angular offset of the box centre from the frame centre, truncated toward zero.
  // A frame dimension below two pixels is treated as two.
  function automatic longint aim_offset(longint pos, longint len,
                                        logic [FRM_W-1:0] size, logic [SPAN_W-1:0] span);
    longint sz;
    longint num;
    sz = (size < 2) ? 2 : size;
    num = (2 * pos + len - sz) * longint'(span) * 256;
    return num / (2 * sz);
  endfunction

  // Saturate to the signed 18 bit angle range.
  function automatic logic signed [ANG_W-1:0] clip_angle(longint v);
    if (v > ANGLE_MAX) return ANGLE_MAX;
    if (v < ANGLE_MIN) return ANGLE_MIN;
    return ANG_W'(v);
  endfunction

  // Advance the shadow state by one accepted word and queue the pose it should produce.
  // An unknown command leaves everything alone and owes no result.
  function automatic void step_gimbal(gimbal_word_t wd);
    pose_word_t p;
    longint dy;
    longint dp;
    longint ny;
    longint np;
    p.kind = KIND_MOTION;
    p.yaw = '0;
    p.pitch = '0;
    p.stamp = '0;
    p.moving = 1'b0;
    case (wd.cmd)
      CMD_BOX: begin
        // Yaw turns against the horizontal error, pitch follows the vertical one.
        dy = aim_offset(wd.x, wd.w, frame_w, yaw_span);
        dp = aim_offset(wd.y, wd.h, frame_h, pitch_span);
        tgt_yaw = clip_angle(longint'(cur_yaw) - dy);
        tgt_pitch = clip_angle(longint'(cur_pitch) + dp);
        p.kind = KIND_TARGET;
        p.yaw = tgt_yaw;
        p.pitch = tgt_pitch;
      end
      CMD_TICK: begin
        tick_total = tick_total + 1;
        // The arithmetic shift floors the Q16 product, negative steps included.
        ny = longint'(cur_yaw) +
             (((longint'(tgt_yaw) - longint'(cur_yaw)) * longint'(gain)) >>> 16);
        np = longint'(cur_pitch) +
             (((longint'(tgt_pitch) - longint'(cur_pitch)) * longint'(gain)) >>> 16);
        // Yaw wraps by one full turn at most, then saturates if a high gain overshot.
        if (ny > HALF_TURN) ny = ny - FULL_TURN;
        else if (ny < -HALF_TURN) ny = ny + FULL_TURN;
        if (np > QUARTER_TURN) np = QUARTER_TURN;
        if (np < -QUARTER_TURN) np = -QUARTER_TURN;
        cur_yaw = clip_angle(ny);
        cur_pitch = ANG_W'(np);
        p.kind = KIND_CURRENT;
        p.yaw = cur_yaw;
        p.pitch = cur_pitch;
        p.stamp = tick_total * {{(TS_W - PER_W){1'b0}}, tick_ms};
      end
      CMD_TRACK: begin
        p.moving = wd.locked;
      end
      default: return;
    endcase
    expected_poses.push_back(p);
  endfunction

  // Input driver. A word stays on the bus until it is taken; between words the
  // sender idles at random unless a steady stretch has been asked for.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        step_gimbal(word_on_bus);
      end
      if (!in_tvalid || in_tready) begin
        if (cmd_backlog.size() != 0 && (no_idle || $urandom_range(0, 99) >= 32)) begin
          word_on_bus = cmd_backlog.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {7'd0, word_on_bus.locked, word_on_bus.h, word_on_bus.w,
                       word_on_bus.y, word_on_bus.x};
          in_tuser <= word_on_bus.cmd;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Output ready. Besides the random idling, one long hold-off on request lets the
  // block back up until it refuses new input words.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      out_tready <= 1'b0;
      hold_left <= 400;
      hold_done <= 1'b1;
    end else begin
      out_tready <= no_idle || ($urandom_range(0, 99) >= 32);
    end
  end

  // Output monitor: every word taken from the block is checked against the oldest
  // expected pose, field by field.
  always @(posedge clk) begin : check_poses
    pose_word_t got;
    pose_word_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.kind = kind_t'(out_tuser);
      got.yaw = out_tdata[ANG_W-1:0];
      got.pitch = out_tdata[2*ANG_W-1:ANG_W];
      got.stamp = out_tdata[2*ANG_W+TS_W-1:2*ANG_W];
      got.moving = out_tdata[2*ANG_W+TS_W];
      if (expected_poses.size() == 0) begin
        mismatches = mismatches + 1;
        if (mismatches <= 10)
          $display("%0t: unexpected word kind %0d yaw %0d pitch %0d ts %0d moving %0d",
                   $realtime, got.kind, got.yaw, got.pitch, got.stamp, got.moving);
      end else begin
        want = expected_poses.pop_front();
        if (got.kind !== want.kind || got.yaw !== want.yaw || got.pitch !== want.pitch ||
            got.stamp !== want.stamp || got.moving !== want.moving) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10) begin
            $display("%0t: expected kind %0d yaw %0d pitch %0d ts %0d moving %0d",
                     $realtime, want.kind, want.yaw, want.pitch, want.stamp, want.moving);
            $display("%0t:      got kind %0d yaw %0d pitch %0d ts %0d moving %0d",
                     $realtime, got.kind, got.yaw, got.pitch, got.stamp, got.moving);
          end
        end
      end
    end
  end

  task automatic queue_word(input cmd_t cmd, input logic [PIX_W-1:0] x,
                            input logic [PIX_W-1:0] y, input logic [PIX_W-1:0] w,
                            input logic [PIX_W-1:0] h, input logic locked);
    gimbal_word_t wd;
    wd.cmd = cmd;
    wd.x = x;
    wd.y = y;
    wd.w = w;
    wd.h = h;
    wd.locked = locked;
    cmd_backlog.push_back(wd);
  endtask

  // Register write: setup cycle, then access cycle; the write lands on the edge that
  // ends the access cycle. The shadow copy keeps only the register's own bits.
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_DW-1:0] val);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (idx)
      REG_FRAME_WIDTH:  frame_w = val[FRM_W-1:0];
      REG_FRAME_HEIGHT: frame_h = val[FRM_W-1:0];
      REG_YAW_SPAN:     yaw_span = val[SPAN_W-1:0];
      REG_PITCH_SPAN:   pitch_span = val[SPAN_W-1:0];
      REG_GAIN:         gain = val[GAIN_W-1:0];
      REG_TICK_PERIOD:  tick_ms = val[PER_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(input int fw, input int fh, input int ys, input int ps,
                               input int g, input int per);
    write_reg(REG_FRAME_WIDTH, fw);
    write_reg(REG_FRAME_HEIGHT, fh);
    write_reg(REG_YAW_SPAN, ys);
    write_reg(REG_PITCH_SPAN, ps);
    write_reg(REG_GAIN, g);
    write_reg(REG_TICK_PERIOD, per);
  endtask

  // Wait until every word has been sent and every pose received, then give the
  // block time to finish anything that owes no result.
  task automatic wait_drained();
    while (cmd_backlog.size() != 0 || in_tvalid || expected_poses.size() != 0)
      @(posedge clk);
    repeat (48) @(posedge clk);
  endtask

  // Mostly realistic tracking: a box inside the frame, a few ticks toward it and
  // sometimes a lock report. The rest is noise over the full field ranges, unknown
  // commands included (those are not counted, as the block ignores them).
  task automatic queue_tracking_burst(input int n);
    int made;
    int fwc;
    int fhc;
    int bx;
    int by;
    int bw;
    int bh;
    int ticks;
    cmd_t c;
    made = 0;
    fwc = (frame_w < 2) ? 2 : ((frame_w > 4096) ? 4096 : frame_w);
    fhc = (frame_h < 2) ? 2 : ((frame_h > 4096) ? 4096 : frame_h);
    while (made < n) begin
      if ($urandom_range(0, 99) < 75) begin
        bx = $urandom_range(0, fwc - 1);
        by = $urandom_range(0, fhc - 1);
        bw = $urandom_range(0, (fwc - bx > 4095) ? 4095 : fwc - bx);
        bh = $urandom_range(0, (fhc - by > 4095) ? 4095 : fhc - by);
        queue_word(CMD_BOX, bx, by, bw, bh, $urandom_range(0, 1));
        ticks = $urandom_range(1, 6);
        repeat (ticks)
          queue_word(CMD_TICK, $urandom_range(0, 4095), $urandom_range(0, 4095),
                     $urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(0, 1));
        made = made + 1 + ticks;
        if ($urandom_range(0, 1) == 1) begin
          queue_word(CMD_TRACK, $urandom_range(0, 4095), $urandom_range(0, 4095),
                     $urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(0, 1));
          made = made + 1;
        end
      end else begin
        c = cmd_t'($urandom_range(0, 3));
        queue_word(c, $urandom_range(0, 4095), $urandom_range(0, 4095),
                   $urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(0, 1));
        if (c != CMD_NONE) made = made + 1;
      end
    end
  endtask

  initial begin : stimulus
    int phase;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed words at the reset settings: every command, field extremes and the
    // ignored command, with ticks in between so the pose actually moves.
    queue_word(CMD_TRACK, 12'd0, 12'd0, 12'd0, 12'd0, 1'b0);
    queue_word(CMD_TRACK, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 1'b1);
    queue_word(CMD_TICK, 12'd0, 12'd0, 12'd0, 12'd0, 1'b0);
    queue_word(CMD_NONE, 12'hFFF, 12'h000, 12'hFFF, 12'h000, 1'b1);
    queue_word(CMD_BOX, 12'd900, 12'd480, 12'd120, 12'd120, 1'b0);
    queue_word(CMD_BOX, 12'd0, 12'd0, 12'd0, 12'd0, 1'b0);
    queue_word(CMD_TICK, 12'd0, 12'd0, 12'd0, 12'd0, 1'b0);
    queue_word(CMD_TICK, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 1'b1);
    queue_word(CMD_BOX, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 1'b1);
    queue_word(CMD_TICK, 12'd0, 12'd0, 12'd0, 12'd0, 1'b0);
    queue_word(CMD_BOX, 12'hAAA, 12'h555, 12'h555, 12'hAAA, 1'b0);
    queue_word(CMD_BOX, 12'h555, 12'hAAA, 12'hAAA, 12'h555, 1'b1);
    queue_word(CMD_TICK, 12'd0, 12'd0, 12'd0, 12'd0, 1'b0);
    queue_word(CMD_NONE, 12'd0, 12'd0, 12'd0, 12'd0, 1'b0);
    queue_word(CMD_BOX, 12'd1919, 12'd1079, 12'd1, 12'd1, 1'b0);
    queue_word(CMD_TICK, 12'd0, 12'd0, 12'd0, 12'd0, 1'b0);
    queue_word(CMD_BOX, 12'd0, 12'd1079, 12'd0, 12'd0, 1'b0);
    queue_word(CMD_TICK, 12'd0, 12'd0, 12'd0, 12'd0, 1'b0);
    queue_word(CMD_TRACK, 12'd0, 12'd0, 12'd0, 12'd0, 1'b1);
    wait_drained();

    // Phases with different register settings: the wide extremes, the small extremes,
    // a frame below two pixels with a gain above one, a moderate setting, an odd
    // oversized frame, and a few random ones inside the documented ranges.
    for (phase = 0; phase < 8; phase++) begin
      case (phase)
        0: apply_setting(4096, 4096, 180, 180, 65536, 1000);
        1: apply_setting(2, 2, 0, 1, 0, 0);
        2: apply_setting(0, 1, 255, 255, 131071, 1023);
        3: apply_setting(640, 480, 90, 45, 20000, 16);
        4: apply_setting(8191, 8191, 180, 180, 98304, 1000);
        default: apply_setting($urandom_range(2, 4096), $urandom_range(2, 4096),
                               $urandom_range(0, 180), $urandom_range(0, 180),
                               $urandom_range(0, 65536), $urandom_range(0, 1000));
      endcase
      no_idle = (phase == 3);
      queue_word(CMD_BOX, 12'd0, 12'd0, 12'd0, 12'd0, 1'b0);
      queue_word(CMD_TICK, 12'd0, 12'd0, 12'd0, 12'd0, 1'b0);
      queue_word(CMD_BOX, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 1'b1);
      queue_word(CMD_TICK, 12'd0, 12'd0, 12'd0, 12'd0, 1'b0);
      queue_tracking_burst(92);
      // In one phase the receiver holds off for a long time while words keep coming.
      if (phase == 1) hold_req = 1'b1;
      // The sender pauses here until every pose has come back.
      wait_drained();
      queue_tracking_burst(92);
      wait_drained();
    end
    no_idle = 1'b0;

    wait_drained();
    if (mismatches == 0 && expected_poses.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #10_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
